>>> hw/rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types of the room spanning tree block: word formats, the control
// group that drives the cells, and the sequencer states.
// ----------------------------------------------------------------------------
package rmst_pkg;

    typedef struct packed {
        logic [6:0] center_col;
        logic [6:0] center_row;
        logic       final_room;
    } t_room_word;

    typedef struct packed {
        logic [3:0] first_room;
        logic [3:0] second_room;
        logic       has_pair;
        logic       final_pair;
    } t_pair_word;

    typedef struct packed {
        logic load;
        logic sweep;
        logic first;
        logic reduce;
        logic merge;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_REDUCE,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/rmst_chan_if.sv
// ----------------------------------------------------------------------------
// rmst_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface rmst_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rmst_cell.sv
// ----------------------------------------------------------------------------
// rmst_cell
// One room of the chain: its centre, its group label, a travelling copy of a
// room that rotates around the ring, its best outgoing pair and the carry of
// the minimum search that moves toward the end of the chain.
// ----------------------------------------------------------------------------
module rmst_cell #(
    parameter int COORD_BITS = 7,
    parameter int IDXW       = 4,
    parameter int CNTW       = 5,
    parameter int KW         = 1 + COORD_BITS + 1 + 4 * IDXW,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  rmst_pkg::t_cell_ctl   i_ctl,
    input  logic [CNTW-1:0]       i_cnt,
    input  logic [CNTW-1:0]       i_n,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_tnext_col,
    input  logic [COORD_BITS-1:0] i_tnext_row,
    input  logic [IDXW-1:0]       i_tnext_lab,
    input  logic [COORD_BITS-1:0] i_head_col,
    input  logic [COORD_BITS-1:0] i_head_row,
    input  logic [IDXW-1:0]       i_head_lab,
    input  logic [IDXW-1:0]       i_head_idx,
    input  logic [KW-1:0]         i_carry,
    input  logic [IDXW-1:0]       i_merge_to,
    input  logic [IDXW-1:0]       i_merge_from,
    output logic [COORD_BITS-1:0] o_tcol,
    output logic [COORD_BITS-1:0] o_trow,
    output logic [IDXW-1:0]       o_tlab,
    output logic [KW-1:0]         o_carry
);
    import rmst_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int CMPW = 1 + DW + 2 * IDXW;

    logic [COORD_BITS-1:0] r_col, r_row, r_tcol, r_trow;
    logic [IDXW-1:0]       r_lab, r_tlab;
    logic [KW-1:0]         r_best, r_carry;
    logic [COORD_BITS-1:0] w_dc, w_dr;
    logic [DW-1:0]         w_dist;
    logic                  w_cand_ok;
    logic [KW-1:0]         w_cand;
    logic                  w_load;

    assign w_load = i_ctl.load && (i_cnt == CNTW'(IDX));
    assign w_dc   = (i_head_col > r_col) ? i_head_col - r_col : r_col - i_head_col;
    assign w_dr   = (i_head_row > r_row) ? i_head_row - r_row : r_row - i_head_row;
    assign w_dist = DW'(w_dc) + DW'(w_dr);

    // Only pairs whose lower room is the travelling one and that cross groups.
    assign w_cand_ok = (i_head_idx < IDXW'(IDX)) && (CNTW'(IDX) < i_n)
                       && (i_head_lab != r_lab);
    assign w_cand    = w_cand_ok ? {1'b0, w_dist, i_head_idx, IDXW'(IDX), i_head_lab, r_lab}
                                 : {KW{1'b1}};

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_col  <= i_col;
            r_row  <= i_row;
            r_tcol <= i_col;
            r_trow <= i_row;
            r_lab  <= IDXW'(IDX);
            r_tlab <= IDXW'(IDX);
        end else if (i_ctl.sweep) begin
            r_tcol <= i_tnext_col;
            r_trow <= i_tnext_row;
            r_tlab <= i_tnext_lab;
        end else if (i_ctl.merge) begin
            if (r_lab == i_merge_from) begin
                r_lab <= i_merge_to;
            end
            if (r_tlab == i_merge_from) begin
                r_tlab <= i_merge_to;
            end
        end
        if (i_ctl.sweep) begin
            if (i_ctl.first || (w_cand[KW-1 -: CMPW] < r_best[KW-1 -: CMPW])) begin
                r_best <= w_cand;
            end
        end
        if (i_ctl.reduce) begin
            r_carry <= (i_carry[KW-1 -: CMPW] < r_best[KW-1 -: CMPW]) ? i_carry : r_best;
        end
    end

    assign o_tcol  = r_tcol;
    assign o_trow  = r_trow;
    assign o_tlab  = r_tlab;
    assign o_carry = r_carry;

endmodule

>>> hw/rtl/room_spanning_tree.sv
// ----------------------------------------------------------------------------
// room_spanning_tree
// Minimum spanning tree over room centres, one cell per room in a ring.
// ----------------------------------------------------------------------------
// Usage: room centres arrive on i_room, one word per cycle while the block
// is loading; rooms past MAX_ROOMS are dropped. The word with final_room set
// starts the run, and i_room.ready stays low until the run is delivered.
// Each kept pair leaves on o_pair in increasing distance order, ties by
// lower then higher room index; the last word carries final_pair. A lone
// room gives one word with has_pair low.
// Steps: each kept pair costs one sweep, in which every room passes once
// around the ring, then a reduce pass in which the minimum ripples down
// the carry chain. A lone room answers on the cycle after its word.
// Stall: a pending word holds o_pair steady and the ring waits until the
// word is taken. Reset returns the block to loading with no rooms stored.
// ----------------------------------------------------------------------------
module room_spanning_tree #(
    parameter int MAX_ROOMS  = 16,
    parameter int COORD_BITS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_chan_if.sink   i_room,
    rmst_chan_if.source o_pair
);
    import rmst_pkg::*;

    localparam int IDXW = $clog2(MAX_ROOMS);
    localparam int CNTW = $clog2(MAX_ROOMS + 1);
    localparam int KW   = 1 + COORD_BITS + 1 + 4 * IDXW;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [IDXW-1:0] r_step, n_step;
    logic [IDXW-1:0] r_edges, n_edges;
    logic            r_single, n_single;
    t_cell_ctl       w_ctl;

    logic                  w_in_acc, w_out_acc, w_step_last, w_final;
    logic [CNTW-1:0]       w_n;
    logic [COORD_BITS-1:0] w_col, w_row;
    logic [KW-1:0]         w_win;
    logic [IDXW-1:0]       w_win_a, w_win_b, w_win_la, w_win_lb;

    logic [COORD_BITS-1:0] w_tcol [MAX_ROOMS];
    logic [COORD_BITS-1:0] w_trow [MAX_ROOMS];
    logic [IDXW-1:0]       w_tlab [MAX_ROOMS];
    logic [KW-1:0]         w_carry[MAX_ROOMS];

    assign w_in_acc    = i_room.valid && i_room.ready;
    assign w_out_acc   = o_pair.valid && o_pair.ready;
    assign w_step_last = (r_step == IDXW'(MAX_ROOMS - 1));
    assign w_n         = (r_cnt < CNTW'(MAX_ROOMS)) ? r_cnt + 1'b1 : r_cnt;
    assign w_col       = COORD_BITS'(i_room.data.center_col);
    assign w_row       = COORD_BITS'(i_room.data.center_row);

    assign w_win    = w_carry[MAX_ROOMS-1];
    assign w_win_a  = w_win[4*IDXW-1 -: IDXW];
    assign w_win_b  = w_win[3*IDXW-1 -: IDXW];
    assign w_win_la = w_win[2*IDXW-1 -: IDXW];
    assign w_win_lb = w_win[IDXW-1:0];
    assign w_final  = r_single || (CNTW'(r_edges) == r_cnt - CNTW'(2));

    // Next state and counters.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_edges  = r_edges;
        n_single = r_single;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    n_cnt = w_n;
                    if (i_room.data.final_room) begin
                        n_step  = '0;
                        n_edges = '0;
                        if (w_n < CNTW'(2)) begin
                            n_single = 1'b1;
                            n_state  = ST_EMIT;
                        end else begin
                            n_single = 1'b0;
                            n_state  = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                n_step = w_step_last ? '0 : r_step + 1'b1;
                if (w_step_last) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_step = w_step_last ? '0 : r_step + 1'b1;
                if (w_step_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    if (w_final) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_edges = r_edges + 1'b1;
                        n_step  = '0;
                        n_state = ST_SWEEP;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Handshakes and cell control.
    always_comb begin
        i_room.ready = 1'b0;
        o_pair.valid = 1'b0;
        w_ctl        = '0;
        case (r_state)
            ST_LOAD: begin
                i_room.ready = 1'b1;
                w_ctl.load   = w_in_acc && (r_cnt < CNTW'(MAX_ROOMS));
            end
            ST_SWEEP: begin
                w_ctl.sweep = 1'b1;
                w_ctl.first = (r_step == '0);
            end
            ST_REDUCE: begin
                w_ctl.reduce = 1'b1;
            end
            ST_EMIT: begin
                o_pair.valid = 1'b1;
                w_ctl.merge  = w_out_acc && !r_single;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    assign o_pair.data.first_room  = r_single ? 4'd0 : 4'(w_win_a);
    assign o_pair.data.second_room = r_single ? 4'd0 : 4'(w_win_b);
    assign o_pair.data.has_pair    = !r_single;
    assign o_pair.data.final_pair  = w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_step   <= '0;
            r_edges  <= '0;
            r_single <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_edges  <= n_edges;
            r_single <= n_single;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_ROOMS; k++) begin : g_cell
            logic [KW-1:0] w_cin;
            if (k == 0) begin : g_head
                assign w_cin = {KW{1'b1}};
            end else begin : g_body
                assign w_cin = w_carry[k-1];
            end
            rmst_cell #(
                .COORD_BITS (COORD_BITS),
                .IDXW       (IDXW),
                .CNTW       (CNTW),
                .KW         (KW),
                .IDX        (k)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_cnt        (r_cnt),
                .i_n          (r_cnt),
                .i_col        (w_col),
                .i_row        (w_row),
                .i_tnext_col  (w_tcol[(k + 1) % MAX_ROOMS]),
                .i_tnext_row  (w_trow[(k + 1) % MAX_ROOMS]),
                .i_tnext_lab  (w_tlab[(k + 1) % MAX_ROOMS]),
                .i_head_col   (w_tcol[0]),
                .i_head_row   (w_trow[0]),
                .i_head_lab   (w_tlab[0]),
                .i_head_idx   (r_step),
                .i_carry      (w_cin),
                .i_merge_to   (w_win_la),
                .i_merge_from (w_win_lb),
                .o_tcol       (w_tcol[k]),
                .o_trow       (w_trow[k]),
                .o_tlab       (w_tlab[k]),
                .o_carry      (w_carry[k])
            );
        end
    endgenerate

`ifndef SYNTH
    a_pair_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_single) |-> (w_win_a < w_win_b))
        else $error("emitted pair is not ordered");
    a_pair_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_single) |-> !w_win[KW-1])
        else $error("no crossing pair found for an unfinished tree");
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_final) |=> (r_state == ST_LOAD && r_cnt == '0))
        else $error("run did not return to loading");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_room.ready && o_pair.valid))
        else $error("loading while a pair is pending");
    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_single) |-> (CNTW'(r_edges) + CNTW'(2) <= r_cnt))
        else $error("more pairs than rooms allow");
`endif

endmodule

>>> tb/room_spanning_tree_tb.sv
// ----------------------------------------------------------------------------
// room_spanning_tree_tb
// Self-checking bench for the room spanning tree block. Room sets are sent
// one word at a time; a behavioral model of Kruskal's method predicts the
// kept pairs of each set, and a monitor compares every pair word as it
// leaves the block. Both sides stall at random, and one phase holds the
// receiver off for a long stretch while rooms are still being sent.
// ----------------------------------------------------------------------------
module room_spanning_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmst_pkg::*;

    localparam int NROOMS = 16;
    localparam int NPAIRS = NROOMS * (NROOMS - 1) / 2;
    localparam int HOLD_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;

    rmst_chan_if #(.t_data(t_room_word)) room_if ();
    rmst_chan_if #(.t_data(t_pair_word)) pair_if ();

    room_spanning_tree #(
        .MAX_ROOMS (NROOMS),
        .COORD_BITS(7)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_room (room_if.sink),
        .o_pair (pair_if.source)
    );

    // Model state: the rooms of the set being loaded.
    logic [6:0] set_col [NROOMS];
    logic [6:0] set_row [NROOMS];
    int         set_count;

    t_pair_word pending_pairs[$];
    int         mismatch_count = 0;
    int         send_idle_pct;
    int         recv_idle_pct;
    logic       hold_on;
    event       hold_start;
    longint     cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predict the kept pairs of the stored set and queue them.
    task automatic build_tree();
        int         pa [NPAIRS];
        int         pb [NPAIRS];
        int         pd [NPAIRS];
        int         parent [NROOMS];
        int         np;
        int         k;
        int         ra;
        int         rb;
        int         w;
        int         nx;
        t_pair_word wd;
        np = 0;
        if (set_count < 2) begin
            wd = '0;
            wd.final_pair = 1'b1;
            pending_pairs = {pending_pairs, wd};
        end else begin
            for (int i = 0; i < set_count - 1; i++) begin
                for (int j = i + 1; j < set_count; j++) begin
                    int d;
                    d = ((set_col[i] > set_col[j]) ? set_col[i] - set_col[j]
                                                   : set_col[j] - set_col[i])
                      + ((set_row[i] > set_row[j]) ? set_row[i] - set_row[j]
                                                   : set_row[j] - set_row[i]);
                    // Stable insertion keeps pair order among equal distances.
                    k = np;
                    while (k > 0 && pd[k-1] > d) begin
                        pa[k] = pa[k-1];
                        pb[k] = pb[k-1];
                        pd[k] = pd[k-1];
                        k--;
                    end
                    pa[k] = i;
                    pb[k] = j;
                    pd[k] = d;
                    np++;
                end
            end
            for (int i = 0; i < NROOMS; i++) parent[i] = i;
            for (int e = 0; e < np; e++) begin
                ra = pa[e];
                while (parent[ra] != ra) ra = parent[ra];
                rb = pb[e];
                while (parent[rb] != rb) rb = parent[rb];
                w = pa[e];
                while (w != ra) begin nx = parent[w]; parent[w] = ra; w = nx; end
                w = pb[e];
                while (w != rb) begin nx = parent[w]; parent[w] = rb; w = nx; end
                if (ra != rb) begin
                    wd = '0;
                    wd.first_room  = 4'(pa[e]);
                    wd.second_room = 4'(pb[e]);
                    wd.has_pair    = 1'b1;
                    pending_pairs = {pending_pairs, wd};
                    parent[rb] = ra;
                end
            end
            pending_pairs[pending_pairs.size() - 1].final_pair = 1'b1;
        end
        set_count = 0;
    endtask

    // Send one room word and update the model once it is accepted. Valid is
    // left high after the accepting edge so that words can follow back to
    // back; the next call lowers it if it idles, as does the end of the test.
    task automatic send_room(input logic [6:0] col, input logic [6:0] row,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            room_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        room_if.valid <= 1'b1;
        room_if.data  <= '{center_col: col, center_row: row, final_room: last};
        @(posedge i_clk);
        while (!room_if.ready) @(posedge i_clk);
        if (set_count < NROOMS) begin
            set_col[set_count] = col;
            set_row[set_count] = row;
            set_count++;
        end
        if (last) build_tree();
        @(negedge i_clk);
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_room(7'($urandom), 7'($urandom), i == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0) @(negedge i_clk);
    endtask

    // Long receiver hold-off, counted here once requested.
    initial begin
        hold_on = 1'b0;
        @(hold_start);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_on = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_on) begin
            pair_if.ready <= 1'b0;
        end else begin
            pair_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("room_spanning_tree test failed");
            $finish;
        end
        if (i_rst_n && pair_if.valid && pair_if.ready) begin
            if (pending_pairs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pair word %p", pair_if.data);
            end else begin
                t_pair_word exp_w;
                exp_w = pending_pairs.pop_front();
                if (exp_w !== pair_if.data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pair word mismatch: expected %p, got %p",
                                 exp_w, pair_if.data);
                end
            end
        end
    end

    task automatic test_single_room();
        send_room(7'd0, 7'd0, 1'b1);
        send_room(7'd127, 7'd127, 1'b1);
    endtask

    task automatic test_extremes();
        send_room(7'd0, 7'd0, 1'b0);
        send_room(7'd127, 7'd127, 1'b1);
        // Equal distances everywhere: ties settle by pair order.
        for (int i = 0; i < 4; i++) send_room(7'd5, 7'd5, i == 3);
        send_room(7'd0, 7'd127, 1'b0);
        send_room(7'd127, 7'd0, 1'b0);
        send_room(7'd64, 7'd64, 1'b1);
    endtask

    task automatic test_overflow();
        // Rooms beyond the store size are dropped; the final one still runs.
        for (int i = 0; i < NROOMS + 3; i++)
            send_room(7'($urandom), 7'($urandom), i == NROOMS + 2);
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(NROOMS + 2, 1)
                                         : $urandom_range(6, 1);
            send_set(n);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        -> hold_start;
        send_set(8);
        send_set(5);
    endtask

    initial begin
        i_rst_n = 1'b0;
        room_if.valid = 1'b0;
        room_if.data = '0;
        set_count = 0;
        send_idle_pct = 8;
        recv_idle_pct = 67;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_room();
        test_extremes();
        test_overflow();
        test_random(170);
        send_idle_pct = 67;
        recv_idle_pct = 8;
        test_random(170);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(140);
        room_if.valid <= 1'b0;

        wait_drained();
        repeat (100) @(negedge i_clk);
        if (mismatch_count == 0 && pending_pairs.size() == 0)
            $display("room_spanning_tree test passed");
        else
            $display("room_spanning_tree test failed");
        $finish;
    end
endmodule
